[hw/rtl/texture_page_rect_blit_assert.svh]
// Assertion macros for the blit RTL.
// Each macro expects i_clk and i_rst_n in scope and is disabled during reset.
`ifndef TEXTURE_PAGE_RECT_BLIT_ASSERT_SVH
`define TEXTURE_PAGE_RECT_BLIT_ASSERT_SVH

// Same-cycle implication
`define TPRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TPRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tprb_pkg.sv]
`default_nettype none

package tprb_pkg;

    // Fixed field widths
    localparam int ADDR_W   = 20;
    localparam int PIX_W    = 16;
    localparam int PAGE_W   = 4;
    localparam int COORD_W  = 8;
    localparam int DIM_W    = 9;
    localparam int DIRTY_W  = 16;
    localparam int PAGE_CODES = 1 << PAGE_W;

    // Bus widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    // Default geometry
    localparam int TPRB_PAGE_COUNT = 16;
    localparam int TPRB_PAGE_SIDE  = 256;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_PIXEL = 1'b1
    } t_req;

    // One input item held in the input register
    typedef struct packed {
        t_req               req_type;
        logic [PAGE_W-1:0]  page_index;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [PIX_W-1:0]   source_pixel;
    } t_item;

    // Input-register status handed to the core
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

    // One write produced by the core
    typedef struct packed {
        logic [ADDR_W-1:0]  write_address;
        logic [PIX_W-1:0]   write_pixel;
        logic               last_pixel;
        logic [DIRTY_W-1:0] dirty_pages;
    } t_result;

    // 555 to 565: shift red and green up one, duplicate green's low bit
    function automatic logic [PIX_W-1:0] rgb555_to_565(input logic [PIX_W-1:0] p);
        rgb555_to_565 = {p[14:5], p[5:0]};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tprb_core.sv]
`default_nettype none

module tprb_core
    import tprb_pkg::*;
#(
    parameter int PAGE_COUNT = TPRB_PAGE_COUNT,
    parameter int PAGE_SIDE  = TPRB_PAGE_SIDE
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_convert_to_565,
    input  wire t_stage_ctl i_ctl,
    input  wire t_item      i_item,
    output logic            o_produce,
    output t_result         o_result
);

    localparam int PAGE_AREA = PAGE_SIDE * PAGE_SIDE;
    localparam logic [ADDR_W-1:0] AREA_MOD = ADDR_W'(PAGE_AREA % (1 << ADDR_W));
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(PAGE_SIDE);

    // Blit state
    logic [DIRTY_W-1:0] r_dirty,     n_dirty;
    logic [ADDR_W-1:0]  r_row_base,  n_row_base;
    logic [DIM_W-1:0]   r_col_count, n_col_count;
    logic [DIM_W-1:0]   r_rows_left, n_rows_left;
    logic [DIM_W-1:0]   r_width,     n_width;
    logic               r_active,    n_active;
    logic               r_mode,      n_mode;

    logic [PAGE_W-1:0]  page_lut [PAGE_CODES];
    logic [PAGE_W-1:0]  page;
    logic [ADDR_W-1:0]  start_base;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   rows_dec;
    logic               is_start;
    logic               is_pixel;

    // Page index reduced modulo the page count
    for (genvar g = 0; g < PAGE_CODES; g++) begin : g_page_lut
        assign page_lut[g] = PAGE_W'(g % PAGE_COUNT);
    end

    assign page       = page_lut[i_item.page_index];
    assign start_base = AREA_MOD * ADDR_W'(page)
                      + ROW_STEP * ADDR_W'(i_item.start_y)
                      + ADDR_W'(i_item.start_x);
    assign is_start   = i_ctl.valid && (i_item.req_type == REQ_START);
    assign is_pixel   = i_ctl.valid && (i_item.req_type == REQ_PIXEL);
    assign col_inc    = r_col_count + DIM_W'(1);
    assign rows_dec   = r_rows_left - DIM_W'(1);

    // Pixel writes only while a rectangle is armed
    assign o_produce = is_pixel && r_active;

    // Next state and result
    always_comb begin
        n_dirty     = r_dirty;
        n_row_base  = r_row_base;
        n_col_count = r_col_count;
        n_rows_left = r_rows_left;
        n_width     = r_width;
        n_active    = r_active;
        n_mode      = r_mode;

        o_result.write_address = r_row_base + ADDR_W'(r_col_count);
        o_result.write_pixel   = r_mode ? rgb555_to_565(i_item.source_pixel)
                                        : i_item.source_pixel;
        o_result.last_pixel    = 1'b0;
        o_result.dirty_pages   = r_dirty;

        if (col_inc == r_width && rows_dec == '0) begin
            o_result.last_pixel = 1'b1;
        end

        if (i_ctl.advance && is_start) begin
            n_dirty     = r_dirty | (DIRTY_W'(1) << page);
            n_row_base  = start_base;
            n_col_count = '0;
            n_width     = i_item.rect_width;
            n_rows_left = i_item.rect_height;
            n_mode      = i_convert_to_565;
            n_active    = (i_item.rect_width != '0) && (i_item.rect_height != '0);
        end else if (i_ctl.advance && o_produce) begin
            if (col_inc == r_width) begin
                n_col_count = '0;
                n_row_base  = r_row_base + ROW_STEP;
                n_rows_left = rows_dec;
                if (rows_dec == '0) begin
                    n_active = 1'b0;
                end
            end else begin
                n_col_count = col_inc;
            end
        end
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty     <= '0;
            r_row_base  <= '0;
            r_col_count <= '0;
            r_rows_left <= '0;
            r_width     <= '0;
            r_active    <= 1'b0;
            r_mode      <= 1'b0;
        end else begin
            r_dirty     <= n_dirty;
            r_row_base  <= n_row_base;
            r_col_count <= n_col_count;
            r_rows_left <= n_rows_left;
            r_width     <= n_width;
            r_active    <= n_active;
            r_mode      <= n_mode;
        end
    end

`include "texture_page_rect_blit_assert.svh"

    // The final write of a rectangle disarms the blit
    `TPRB_ASSERT_NEXT(a_last_disarms, i_ctl.advance && o_produce && o_result.last_pixel, !r_active, "blit still active after last write")

    // Dirty flags only ever get set
    `TPRB_ASSERT_NEXT(a_dirty_sticky, 1'b1, (r_dirty & $past(r_dirty)) == $past(r_dirty), "dirty flag cleared")

    // An armed blit always has rows and a width
    `TPRB_ASSERT_NOW(a_active_dims, r_active, (r_width != '0) && (r_rows_left != '0), "active blit with empty dimensions")

    // No page beyond the page count is ever marked
    `TPRB_ASSERT_NOW(a_dirty_range, 1'b1, (32'(r_dirty) >> PAGE_COUNT) == '0, "dirty flag beyond page count")

endmodule

`default_nettype wire

[hw/rtl/texture_page_rect_blit.sv]
// Rectangle blit into a paged texture buffer, sixteen pages by default.
// Slave stream: tuser = req_type (0 start, 1 pixel); tdata carries the start
// fields and the source pixel. A start transfer picks the page, places the
// rectangle and marks the page dirty; it returns nothing. Each following pixel
// transfer returns one write on the master stream, tlast on the final write
// of the rectangle. Pixels with no armed rectangle are dropped.
// Config channel: one bit, 1 converts RGB555 to RGB565; it is sampled by each
// start transfer, so change it only while the block is idle.
// A pixel is held in the input register, then in the output register, which
// drives the master stream. Throughput: one item per clock, set by the single
// input register and the single output register, with no stalls of its own.
// When the receiver stalls the output register holds and the input register
// keeps taking items until it is full; tready then drops on the slave side.
// Reset (synchronous, active low) clears the dirty flags, disarms any blit,
// empties both registers and sets the conversion mode to copy.
`default_nettype none

module texture_page_rect_blit
    import tprb_pkg::*;
#(
    parameter int PAGE_COUNT = TPRB_PAGE_COUNT,
    parameter int PAGE_SIDE  = TPRB_PAGE_SIDE
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Config write
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [0:0]           i_cfg_data,     // convert_to_565
    // Slave stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // page_index[3:0], start_x[11:4], start_y[19:12], rect_width[28:20],
    // rect_height[37:29], source_pixel[53:38], zero pad[55:54]
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [0:0]           i_s_tuser,      // req_type
    // Master stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // write_address[19:0], write_pixel[35:20], dirty_pages[51:36], zero pad[55:52]
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic                      o_m_tlast       // last_pixel
);

    logic       r_convert;
    logic       r_s_valid;
    t_item      r_s_item;
    logic       r_m_valid;
    t_result    r_m_result;

    t_stage_ctl stage_ctl;
    t_result    core_result;
    logic       core_produce;
    logic       out_free;
    logic       s_accept;

    // Config register always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_convert <= 1'b0;
        end else if (i_cfg_valid) begin
            r_convert <= i_cfg_data[0];
        end
    end

    // Advance the input register when its item needs no slot or one is free
    assign out_free          = !r_m_valid || i_m_tready;
    assign stage_ctl.valid   = r_s_valid;
    assign stage_ctl.advance = r_s_valid && (!core_produce || out_free);
    assign o_s_tready        = !r_s_valid || stage_ctl.advance;
    assign s_accept          = i_s_tvalid && o_s_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (s_accept) begin
            r_s_valid <= 1'b1;
        end else if (stage_ctl.advance) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s_item.req_type     <= t_req'(i_s_tuser[0]);
            r_s_item.page_index   <= i_s_tdata[3:0];
            r_s_item.start_x      <= i_s_tdata[11:4];
            r_s_item.start_y      <= i_s_tdata[19:12];
            r_s_item.rect_width   <= i_s_tdata[28:20];
            r_s_item.rect_height  <= i_s_tdata[37:29];
            r_s_item.source_pixel <= i_s_tdata[53:38];
        end
    end

    tprb_core #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SIDE  (PAGE_SIDE)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_convert_to_565 (r_convert),
        .i_ctl            (stage_ctl),
        .i_item           (r_s_item),
        .o_produce        (core_produce),
        .o_result         (core_result)
    );

    // Output register: load a new write, drop the old one once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (stage_ctl.advance && core_produce) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ctl.advance && core_produce) begin
            r_m_result <= core_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_m_result.last_pixel;
    assign o_m_tdata  = {4'b0000, r_m_result.dirty_pages, r_m_result.write_pixel,
                         r_m_result.write_address};

endmodule

`default_nettype wire
